@@ hdl/ptc_pkg.sv @@
// Shared constants for the pressure/temperature compensation pipeline.
// Register map, field widths, scaling shifts and temperature thresholds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    // Register map: register i sits at byte address 4*i
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_SENS     = 3'd0,
        REG_OFFSET   = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5,
        REG_MODEL    = 3'd6
    } reg_idx_t;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 32;

    // Internal datapath widths, sized from the value ranges
    localparam int DT_W    = 25;  // D2 - C5*256
    localparam int MUL_W   = 42;  // 17-bit coefficient times dT
    localparam int DTSQ_W  = 48;  // dT squared
    localparam int SENS_W  = 36;
    localparam int OFF_W   = 37;
    localparam int TEMP_W  = 19;  // first-order temperature
    localparam int XSQ_W   = 34;  // (TEMP-2000)^2
    localparam int YSQ_W   = 35;  // (TEMP+1500)^2
    localparam int TI_W    = 17;
    localparam int LO_W    = 18;  // low slice of SENS for the split product
    localparam int PLO_W   = 42;
    localparam int PHI_W   = 43;
    localparam int PROD_W  = 61;
    localparam int Q1_W    = 40;
    localparam int DIFF_W  = 41;

    // Scaling shifts (02BA / 30BA)
    localparam int C5_SH        = 8;
    localparam int C1_SH_02     = 16;
    localparam int C1_SH_30     = 15;
    localparam int C2_SH_02     = 17;
    localparam int C2_SH_30     = 16;
    localparam int TCS_SH_02    = 7;
    localparam int TCS_SH_30    = 8;
    localparam int TCO_SH_02    = 6;
    localparam int TCO_SH_30    = 7;
    localparam int TEMPSENS_SH  = 23;
    localparam int PROD_SH      = 21;
    localparam int P_SH_02      = 15;
    localparam int P_SH_30      = 13;

    // Temperature thresholds in 0.01 degC
    localparam int TEMP_REF   = 2000;
    localparam int TEMP_VCOLD = -1600;
    localparam int TEMP_YOFS  = 1500;

    // Pipeline depth from sample register to result register
    localparam int NUM_STAGES = 11;

endpackage

`default_nettype wire

@@ hdl/pressure_temp_compensation_top.sv @@
// Pressure/temperature compensation top level: first- and second-order
// compensation of raw D1/D2 samples in an 11-stage pipeline, APB config.
// Depends on ptc_pkg.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------------
//   sample   | in        | sample_valid / sample_stall | pressure_raw, temp_raw
//   result   | out       | result_valid / result_stall | pressure_out, temp_out
//   config   | in        | psel, penable, pwrite       | paddr, pwdata, prdata
//
// One sample beat is taken per cycle while the pipeline is not stalled; each
// result passes through the 11 register stages of the datapath (three multiply
// stages, including a split 24x36 product, and the truncating divides).
// A stalled result freezes the whole pipeline; sample_stall follows it.
// Reset clears the calibration registers and the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temp_compensation_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ptc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [ptc_pkg::DATA_W-1:0]        pwdata,
    output logic      [ptc_pkg::DATA_W-1:0]        prdata,
    output logic                                   pready,
    // sample channel
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire logic [ptc_pkg::RAW_W-1:0]         pressure_raw,
    input  wire logic [ptc_pkg::RAW_W-1:0]         temp_raw,
    // result channel
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic signed [ptc_pkg::OUT_W-1:0]       pressure_out,
    output logic signed [ptc_pkg::OUT_W-1:0]       temp_out
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ptc_pkg::COEF_W-1:0] coef_sens_reg;
    logic [ptc_pkg::COEF_W-1:0] coef_offset_reg;
    logic [ptc_pkg::COEF_W-1:0] coef_tcs_reg;
    logic [ptc_pkg::COEF_W-1:0] coef_tco_reg;
    logic [ptc_pkg::COEF_W-1:0] coef_tref_reg;
    logic [ptc_pkg::COEF_W-1:0] coef_tempsens_reg;
    logic                       model_select_reg;
    logic                       cfg_write;
    logic [2:0]                 cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[ptc_pkg::ADDR_W-1:2];

    // Write the addressed register on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_sens_reg     <= '0;
            coef_offset_reg   <= '0;
            coef_tcs_reg      <= '0;
            coef_tco_reg      <= '0;
            coef_tref_reg     <= '0;
            coef_tempsens_reg <= '0;
            model_select_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                ptc_pkg::REG_SENS:     coef_sens_reg     <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_OFFSET:   coef_offset_reg   <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TCS:      coef_tcs_reg      <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TCO:      coef_tco_reg      <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TREF:     coef_tref_reg     <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TEMPSENS: coef_tempsens_reg <= pwdata[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_MODEL:    model_select_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            ptc_pkg::REG_SENS:     prdata = {16'h0000, coef_sens_reg};
            ptc_pkg::REG_OFFSET:   prdata = {16'h0000, coef_offset_reg};
            ptc_pkg::REG_TCS:      prdata = {16'h0000, coef_tcs_reg};
            ptc_pkg::REG_TCO:      prdata = {16'h0000, coef_tco_reg};
            ptc_pkg::REG_TREF:     prdata = {16'h0000, coef_tref_reg};
            ptc_pkg::REG_TEMPSENS: prdata = {16'h0000, coef_tempsens_reg};
            ptc_pkg::REG_MODEL:    prdata = {31'h0, model_select_reg};
            default:               prdata = '0;
        endcase
    end

    logic is02;
    assign is02 = model_select_reg;

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together
    // ------------------------------------------------------------------
    logic [ptc_pkg::NUM_STAGES-1:0] valid_reg;
    logic                           advance;

    assign result_valid = valid_reg[ptc_pkg::NUM_STAGES-1];
    assign advance      = !result_valid || !result_stall;
    assign sample_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[ptc_pkg::NUM_STAGES-2:0], sample_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5*256
    // ------------------------------------------------------------------
    logic        [ptc_pkg::RAW_W-1:0]  d1_s1_reg;
    logic signed [ptc_pkg::DT_W-1:0]   dt_s1_reg;
    logic signed [ptc_pkg::DT_W:0]     dt_wide;

    assign dt_wide = $signed({2'b00, temp_raw})
                   - $signed({2'b00, coef_tref_reg, 8'h00});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_s1_reg <= pressure_raw;
            dt_s1_reg <= dt_wide[ptc_pkg::DT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: coefficient products and dT squared
    // ------------------------------------------------------------------
    logic        [ptc_pkg::RAW_W-1:0]  d1_s2_reg;
    logic signed [ptc_pkg::MUL_W-1:0]  mc3_s2_reg, mc4_s2_reg, mc6_s2_reg;
    logic        [ptc_pkg::DTSQ_W-1:0] dtsq_s2_reg;
    logic signed [ptc_pkg::MUL_W-1:0]  mc3_next, mc4_next, mc6_next;
    logic signed [2*ptc_pkg::DT_W-1:0] dtsq_full;

    assign mc3_next  = $signed({1'b0, coef_tcs_reg}) * dt_s1_reg;
    assign mc4_next  = $signed({1'b0, coef_tco_reg}) * dt_s1_reg;
    assign mc6_next  = $signed({1'b0, coef_tempsens_reg}) * dt_s1_reg;
    assign dtsq_full = dt_s1_reg * dt_s1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_s2_reg   <= d1_s1_reg;
            mc3_s2_reg  <= mc3_next;
            mc4_s2_reg  <= mc4_next;
            mc6_s2_reg  <= mc6_next;
            dtsq_s2_reg <= dtsq_full[ptc_pkg::DTSQ_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first-order SENS, OFF, TEMP; candidate Ti terms
    // ------------------------------------------------------------------
    logic        [ptc_pkg::RAW_W-1:0]  d1_s3_reg;
    logic signed [ptc_pkg::SENS_W-1:0] sens1_s3_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off1_s3_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp_s3_reg;
    logic        [ptc_pkg::TI_W-1:0]   ticold_s3_reg, tiwarm_s3_reg;

    logic signed [ptc_pkg::SENS_W-1:0] sens1_next;
    logic signed [ptc_pkg::OFF_W-1:0]  off1_next;
    logic signed [ptc_pkg::TEMP_W-1:0] temp_next;
    logic        [ptc_pkg::TI_W-1:0]   ticold_next, tiwarm_next;

    always_comb
    begin
        logic signed [ptc_pkg::MUL_W-1:0]  b3, b4, b6, q3, q4, q6;
        logic        [ptc_pkg::SENS_W-1:0] c1_term;
        logic        [ptc_pkg::OFF_W-1:0]  c2_term;
        logic        [ptc_pkg::DTSQ_W+3:0] m11;
        logic        [ptc_pkg::DTSQ_W+1:0] m3;

        // truncate toward zero: bias negative values before the shift
        b3 = mc3_s2_reg;
        b4 = mc4_s2_reg;
        b6 = mc6_s2_reg;
        if (mc3_s2_reg[ptc_pkg::MUL_W-1])
            b3 = mc3_s2_reg
               + (is02 ? ptc_pkg::MUL_W'((1 << ptc_pkg::TCS_SH_02) - 1)
                       : ptc_pkg::MUL_W'((1 << ptc_pkg::TCS_SH_30) - 1));
        if (mc4_s2_reg[ptc_pkg::MUL_W-1])
            b4 = mc4_s2_reg
               + (is02 ? ptc_pkg::MUL_W'((1 << ptc_pkg::TCO_SH_02) - 1)
                       : ptc_pkg::MUL_W'((1 << ptc_pkg::TCO_SH_30) - 1));
        if (mc6_s2_reg[ptc_pkg::MUL_W-1])
            b6 = mc6_s2_reg + ptc_pkg::MUL_W'((1 << ptc_pkg::TEMPSENS_SH) - 1);

        q3 = is02 ? (b3 >>> ptc_pkg::TCS_SH_02) : (b3 >>> ptc_pkg::TCS_SH_30);
        q4 = is02 ? (b4 >>> ptc_pkg::TCO_SH_02) : (b4 >>> ptc_pkg::TCO_SH_30);
        q6 = b6 >>> ptc_pkg::TEMPSENS_SH;

        c1_term = is02 ? (ptc_pkg::SENS_W'(coef_sens_reg) << ptc_pkg::C1_SH_02)
                       : (ptc_pkg::SENS_W'(coef_sens_reg) << ptc_pkg::C1_SH_30);
        c2_term = is02 ? (ptc_pkg::OFF_W'(coef_offset_reg) << ptc_pkg::C2_SH_02)
                       : (ptc_pkg::OFF_W'(coef_offset_reg) << ptc_pkg::C2_SH_30);

        sens1_next = $signed(c1_term + q3[ptc_pkg::SENS_W-1:0]);
        off1_next  = $signed(c2_term + q4[ptc_pkg::OFF_W-1:0]);
        temp_next  = $signed(q6[ptc_pkg::TEMP_W-1:0]
                             + ptc_pkg::TEMP_W'(ptc_pkg::TEMP_REF));

        // cold Ti: 11*dT^2 >> 35 (02BA) or 3*dT^2 >> 33 (30BA)
        m11 = {dtsq_s2_reg, 3'b000} + {2'b00, dtsq_s2_reg, 1'b0} + {4'h0, dtsq_s2_reg};
        m3  = {dtsq_s2_reg, 1'b0} + {2'b00, dtsq_s2_reg};
        ticold_next = is02 ? m11[51:35] : m3[49:33];
        // warm Ti (30BA): 2*dT^2 >> 37
        tiwarm_next = ptc_pkg::TI_W'(dtsq_s2_reg[ptc_pkg::DTSQ_W-1:36]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_s3_reg     <= d1_s2_reg;
            sens1_s3_reg  <= sens1_next;
            off1_s3_reg   <= off1_next;
            temp_s3_reg   <= temp_next;
            ticold_s3_reg <= ticold_next;
            tiwarm_s3_reg <= tiwarm_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares of (TEMP-2000) and (TEMP+1500), temperature bands
    // ------------------------------------------------------------------
    logic        [ptc_pkg::RAW_W-1:0]  d1_s4_reg;
    logic signed [ptc_pkg::SENS_W-1:0] sens1_s4_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off1_s4_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp_s4_reg;
    logic        [ptc_pkg::TI_W-1:0]   ticold_s4_reg, tiwarm_s4_reg;
    logic        [ptc_pkg::XSQ_W-1:0]  xsq_s4_reg;
    logic        [ptc_pkg::YSQ_W-1:0]  ysq_s4_reg;
    logic                              cold_s4_reg, vcold_s4_reg;

    logic signed [ptc_pkg::TEMP_W-1:0]   x_val, y_val;
    logic signed [2*ptc_pkg::TEMP_W-1:0] xsq_full, ysq_full;

    assign x_val    = ptc_pkg::TEMP_W'(temp_s3_reg - ptc_pkg::TEMP_REF);
    assign y_val    = ptc_pkg::TEMP_W'(temp_s3_reg + ptc_pkg::TEMP_YOFS);
    assign xsq_full = x_val * x_val;
    assign ysq_full = y_val * y_val;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_s4_reg     <= d1_s3_reg;
            sens1_s4_reg  <= sens1_s3_reg;
            off1_s4_reg   <= off1_s3_reg;
            temp_s4_reg   <= temp_s3_reg;
            ticold_s4_reg <= ticold_s3_reg;
            tiwarm_s4_reg <= tiwarm_s3_reg;
            xsq_s4_reg    <= xsq_full[ptc_pkg::XSQ_W-1:0];
            ysq_s4_reg    <= ysq_full[ptc_pkg::YSQ_W-1:0];
            cold_s4_reg   <= (temp_s3_reg < ptc_pkg::TEMP_REF);
            vcold_s4_reg  <= (temp_s3_reg <= ptc_pkg::TEMP_VCOLD);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: second-order Ti, OFFi and SENSi, the last two wrapped to 32 bits
    // ------------------------------------------------------------------
    logic        [ptc_pkg::RAW_W-1:0]  d1_s5_reg;
    logic signed [ptc_pkg::SENS_W-1:0] sens1_s5_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off1_s5_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temp_s5_reg;
    logic        [ptc_pkg::TI_W-1:0]   ti_s5_reg;
    logic        [ptc_pkg::OUT_W-1:0]  offi_s5_reg, sensi_s5_reg;

    logic        [ptc_pkg::TI_W-1:0]   ti_next;
    logic        [ptc_pkg::OUT_W-1:0]  offi_next, sensi_next;

    always_comb
    begin
        logic [ptc_pkg::XSQ_W+4:0] x31;
        logic [ptc_pkg::XSQ_W+5:0] x63;
        logic [ptc_pkg::XSQ_W+1:0] x3;
        logic [ptc_pkg::XSQ_W+2:0] x5;
        logic [ptc_pkg::OUT_W-1:0] y7, y4;

        x31 = {xsq_s4_reg, 5'b00000} - {5'b00000, xsq_s4_reg};
        x63 = {xsq_s4_reg, 6'b000000} - {6'b000000, xsq_s4_reg};
        x3  = {xsq_s4_reg, 1'b0} + {2'b00, xsq_s4_reg};
        x5  = {xsq_s4_reg, 2'b00} + {3'b000, xsq_s4_reg};
        y7  = {ysq_s4_reg[28:0], 3'b000} - ysq_s4_reg[ptc_pkg::OUT_W-1:0];
        y4  = {ysq_s4_reg[29:0], 2'b00};

        ti_next    = '0;
        offi_next  = '0;
        sensi_next = '0;
        priority if (is02)
        begin
            // 02BA: correction only below 20 degC
            if (cold_s4_reg)
            begin
                ti_next    = ticold_s4_reg;
                offi_next  = x31[34:3];
                sensi_next = x63[36:5];
            end
        end
        else if (cold_s4_reg)
        begin
            ti_next    = ticold_s4_reg;
            offi_next  = x3[32:1];
            sensi_next = x5[34:3];
            // very cold: add the (TEMP+1500)^2 terms
            if (vcold_s4_reg)
            begin
                offi_next  = x3[32:1] + y7;
                sensi_next = x5[34:3] + y4;
            end
        end
        else
        begin
            ti_next    = tiwarm_s4_reg;
            offi_next  = ptc_pkg::OUT_W'(xsq_s4_reg[ptc_pkg::XSQ_W-1:4]);
            sensi_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_s5_reg    <= d1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            off1_s5_reg  <= off1_s4_reg;
            temp_s5_reg  <= temp_s4_reg;
            ti_s5_reg    <= ti_next;
            offi_s5_reg  <= offi_next;
            sensi_s5_reg <= sensi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: apply second-order terms
    // ------------------------------------------------------------------
    logic        [ptc_pkg::RAW_W-1:0]  d1_s6_reg;
    logic signed [ptc_pkg::SENS_W-1:0] sens2_s6_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off2_s6_reg;
    logic        [ptc_pkg::OUT_W-1:0]  temp_s6_reg;

    logic signed [ptc_pkg::SENS_W-1:0] sens2_next;
    logic signed [ptc_pkg::OFF_W-1:0]  off2_next;
    logic        [ptc_pkg::OUT_W-1:0]  temp2_next;

    assign sens2_next = sens1_s5_reg - ptc_pkg::SENS_W'($signed(sensi_s5_reg));
    assign off2_next  = off1_s5_reg - ptc_pkg::OFF_W'($signed(offi_s5_reg));
    assign temp2_next = ptc_pkg::OUT_W'(temp_s5_reg) - ptc_pkg::OUT_W'(ti_s5_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_s6_reg    <= d1_s5_reg;
            sens2_s6_reg <= sens2_next;
            off2_s6_reg  <= off2_next;
            temp_s6_reg  <= temp2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS as two partial products
    // ------------------------------------------------------------------
    logic        [ptc_pkg::PLO_W-1:0]  pplo_s7_reg;
    logic signed [ptc_pkg::PHI_W-1:0]  pphi_s7_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off2_s7_reg;
    logic        [ptc_pkg::OUT_W-1:0]  temp_s7_reg;

    logic        [ptc_pkg::PLO_W-1:0]  pplo_next;
    logic signed [ptc_pkg::PHI_W-1:0]  pphi_next;

    assign pplo_next = d1_s6_reg * sens2_s6_reg[ptc_pkg::LO_W-1:0];
    assign pphi_next = $signed({1'b0, d1_s6_reg})
                     * $signed(sens2_s6_reg[ptc_pkg::SENS_W-1:ptc_pkg::LO_W]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pplo_s7_reg <= pplo_next;
            pphi_s7_reg <= pphi_next;
            off2_s7_reg <= off2_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: combine the partial products
    // ------------------------------------------------------------------
    logic signed [ptc_pkg::PROD_W-1:0] prod_s8_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off2_s8_reg;
    logic        [ptc_pkg::OUT_W-1:0]  temp_s8_reg;
    logic signed [ptc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = $signed({pphi_s7_reg, {ptc_pkg::LO_W{1'b0}}})
                     + $signed({{(ptc_pkg::PROD_W-ptc_pkg::PLO_W){1'b0}}, pplo_s7_reg});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_s8_reg <= prod_next;
            off2_s8_reg <= off2_s7_reg;
            temp_s8_reg <= temp_s7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: D1*SENS / 2^21, truncating toward zero
    // ------------------------------------------------------------------
    logic signed [ptc_pkg::Q1_W-1:0]   q1_s9_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  off2_s9_reg;
    logic        [ptc_pkg::OUT_W-1:0]  temp_s9_reg;
    logic signed [ptc_pkg::PROD_W-1:0] prod_bias, prod_shr;

    assign prod_bias = prod_s8_reg[ptc_pkg::PROD_W-1]
                     ? prod_s8_reg + ptc_pkg::PROD_W'((1 << ptc_pkg::PROD_SH) - 1)
                     : prod_s8_reg;
    assign prod_shr  = prod_bias >>> ptc_pkg::PROD_SH;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q1_s9_reg   <= prod_shr[ptc_pkg::Q1_W-1:0];
            off2_s9_reg <= off2_s8_reg;
            temp_s9_reg <= temp_s8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: subtract OFF
    // ------------------------------------------------------------------
    logic signed [ptc_pkg::DIFF_W-1:0] diff_s10_reg;
    logic        [ptc_pkg::OUT_W-1:0]  temp_s10_reg;
    logic signed [ptc_pkg::DIFF_W-1:0] diff_next;

    assign diff_next = ptc_pkg::DIFF_W'(q1_s9_reg) - ptc_pkg::DIFF_W'(off2_s9_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_s10_reg <= diff_next;
            temp_s10_reg <= temp_s9_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: final scaling into the result register
    // ------------------------------------------------------------------
    logic signed [ptc_pkg::OUT_W-1:0]  pressure_out_reg;
    logic signed [ptc_pkg::OUT_W-1:0]  temp_out_reg;
    logic signed [ptc_pkg::DIFF_W-1:0] diff_bias, diff_shr;

    always_comb
    begin
        diff_bias = diff_s10_reg;
        if (diff_s10_reg[ptc_pkg::DIFF_W-1])
            diff_bias = diff_s10_reg
                      + (is02 ? ptc_pkg::DIFF_W'((1 << ptc_pkg::P_SH_02) - 1)
                              : ptc_pkg::DIFF_W'((1 << ptc_pkg::P_SH_30) - 1));
        diff_shr = is02 ? (diff_bias >>> ptc_pkg::P_SH_02)
                        : (diff_bias >>> ptc_pkg::P_SH_30);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pressure_out_reg <= diff_shr[ptc_pkg::OUT_W-1:0];
            temp_out_reg     <= temp_s10_reg;
        end
    end

    assign pressure_out = pressure_out_reg;
    assign temp_out     = temp_out_reg;

`ifndef SYNTHESIS
    // an accepted sample beat enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> valid_reg[0])
        else $error("accepted sample did not enter stage 1");

    // a stalled result freezes every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(valid_reg))
        else $error("pipeline moved while result stalled");

    // a model register write lands on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_idx == ptc_pkg::REG_MODEL)
        |=> model_select_reg == $past(pwdata[0]))
        else $error("model select write lost");
`endif

endmodule

`default_nettype wire

@@ dv/ptc_tb_pkg.sv @@
// Scoreboard for the pressure/temperature compensation testbench: a copy of
// the calibration registers, the second-order compensation predictor and the
// queue of expected readings. Depends on ptc_pkg.
`timescale 1ns / 1ps

package ptc_tb_pkg;

    // Divisors of the compensation formulas; the Ti divisors do not fit in 32 bits
    localparam longint TEMP_DIV       = 64'sd8388608;
    localparam longint PROD_DIV       = 64'sd2097152;
    localparam longint TI_DIV_02      = 64'sd34359738368;
    localparam longint TI_DIV_30_COLD = 64'sd8589934592;
    localparam longint TI_DIV_30_WARM = 64'sd137438953472;

    typedef struct {
        logic signed [ptc_pkg::OUT_W-1:0] pressure;
        logic signed [ptc_pkg::OUT_W-1:0] temp;
    } reading_t;

    // Wrap to 32 bits and sign-extend back
    function automatic longint wrap32(longint v);
        return longint'(int'(v));
    endfunction

    class compensation_checker;

        logic [ptc_pkg::COEF_W-1:0] c_sens;
        logic [ptc_pkg::COEF_W-1:0] c_offset;
        logic [ptc_pkg::COEF_W-1:0] c_tcs;
        logic [ptc_pkg::COEF_W-1:0] c_tco;
        logic [ptc_pkg::COEF_W-1:0] c_tref;
        logic [ptc_pkg::COEF_W-1:0] c_tempsens;
        logic                       is_02ba;

        reading_t expected_readings[$];
        int       failures;
        int       samples_seen;
        int       readings_checked;

        function new();
            c_sens     = '0;
            c_offset   = '0;
            c_tcs      = '0;
            c_tco      = '0;
            c_tref     = '0;
            c_tempsens = '0;
            is_02ba    = 1'b0;
            failures   = 0;
            samples_seen     = 0;
            readings_checked = 0;
        endfunction

        // Mirror a register write; unmapped indexes are dropped
        function void write_register(logic [2:0] idx, logic [ptc_pkg::DATA_W-1:0] value);
            case (idx)
                ptc_pkg::REG_SENS:     c_sens     = value[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_OFFSET:   c_offset   = value[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TCS:      c_tcs      = value[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TCO:      c_tco      = value[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TREF:     c_tref     = value[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_TEMPSENS: c_tempsens = value[ptc_pkg::COEF_W-1:0];
                ptc_pkg::REG_MODEL:    is_02ba    = value[0];
                default:      ;
            endcase
        endfunction

        // First- and second-order compensation of one raw sample pair
        function reading_t compensate(logic [ptc_pkg::RAW_W-1:0] d1_raw,
                                      logic [ptc_pkg::RAW_W-1:0] d2_raw);
            longint   d1, d2, c1, c2, c3, c4, c5, c6;
            longint   dt, sens, off, temp, x, y, ti, offi, sensi, p;
            reading_t r;
            d1 = longint'(d1_raw);
            d2 = longint'(d2_raw);
            c1 = longint'(c_sens);
            c2 = longint'(c_offset);
            c3 = longint'(c_tcs);
            c4 = longint'(c_tco);
            c5 = longint'(c_tref);
            c6 = longint'(c_tempsens);
            ti    = 0;
            offi  = 0;
            sensi = 0;

            dt = d2 - c5 * 256;
            if (is_02ba)
            begin
                sens = c1 * 65536 + (c3 * dt) / 128;
                off  = c2 * 131072 + (c4 * dt) / 64;
            end
            else
            begin
                sens = c1 * 32768 + (c3 * dt) / 256;
                off  = c2 * 65536 + (c4 * dt) / 128;
            end

            temp = wrap32(ptc_pkg::TEMP_REF + (dt * c6) / TEMP_DIV);
            x    = temp - ptc_pkg::TEMP_REF;

            // Second-order terms: cold, very cold (30BA only) and warm (30BA only)
            if (is_02ba)
            begin
                if (temp / 100 < 20)
                begin
                    ti    = wrap32((11 * dt * dt) / TI_DIV_02);
                    offi  = wrap32((31 * x * x) / 8);
                    sensi = wrap32((63 * x * x) / 32);
                end
            end
            else if (temp / 100 < 20)
            begin
                ti    = wrap32((3 * dt * dt) / TI_DIV_30_COLD);
                offi  = wrap32((3 * x * x) / 2);
                sensi = wrap32((5 * x * x) / 8);
                if (temp / 100 < -15)
                begin
                    y     = temp + ptc_pkg::TEMP_YOFS;
                    offi  = wrap32(offi + wrap32(7 * y * y));
                    sensi = wrap32(sensi + wrap32(4 * y * y));
                end
            end
            else
            begin
                ti    = wrap32((2 * dt * dt) / TI_DIV_30_WARM);
                offi  = wrap32((x * x) / 16);
                sensi = 0;
            end

            off  = off - offi;
            sens = sens - sensi;
            temp = wrap32(temp - ti);

            if (is_02ba)
                p = ((d1 * sens) / PROD_DIV - off) / 32768;
            else
                p = ((d1 * sens) / PROD_DIV - off) / 8192;

            r.pressure = p[ptc_pkg::OUT_W-1:0];
            r.temp     = temp[ptc_pkg::OUT_W-1:0];
            return r;
        endfunction

        // Queue the expected reading for an accepted sample beat
        function void note_sample(logic [ptc_pkg::RAW_W-1:0] d1,
                                  logic [ptc_pkg::RAW_W-1:0] d2);
            expected_readings.push_back(compensate(d1, d2));
            samples_seen++;
        endfunction

        // Compare an accepted result beat with the oldest expectation
        function void check_result(logic signed [ptc_pkg::OUT_W-1:0] pressure_out,
                                   logic signed [ptc_pkg::OUT_W-1:0] temp_out);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("result beat with no sample pending: pressure_out %0d, temp_out %0d",
                       pressure_out, temp_out);
                failures++;
                return;
            end
            want = expected_readings.pop_front();
            readings_checked++;
            if (pressure_out !== want.pressure)
            begin
                $error("pressure_out mismatch: expected %0d, actual %0d",
                       want.pressure, pressure_out);
                failures++;
            end
            if (temp_out !== want.temp)
            begin
                $error("temp_out mismatch: expected %0d, actual %0d", want.temp, temp_out);
                failures++;
            end
        endfunction

        function int pending_count();
            return expected_readings.size();
        endfunction

    endclass

endpackage

@@ dv/tb_pressure_temp_compensation_top.sv @@
// Testbench top for pressure_temp_compensation_top: drives calibration over
// APB and sample beats under random idling, checks results in order.
// Depends on ptc_pkg and ptc_tb_pkg.
`timescale 1ns / 1ps

module tb_pressure_temp_compensation_top;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    localparam logic [2:0] UNMAPPED_IDX   = 3'd7;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         HOLD_OFF_LEN   = 300;
    localparam int         RANDOM_PHASES  = 8;
    localparam int         ITEMS_PER_PHASE = 135;
    localparam logic [ptc_pkg::RAW_W-1:0] RAW_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [ptc_pkg::ADDR_W-1:0]        paddr = '0;
    logic [ptc_pkg::DATA_W-1:0]        pwdata = '0;
    logic [ptc_pkg::DATA_W-1:0]        prdata;
    logic                              pready;

    logic                              sample_valid = 1'b0;
    logic                              sample_stall;
    logic [ptc_pkg::RAW_W-1:0]         pressure_raw = '0;
    logic [ptc_pkg::RAW_W-1:0]         temp_raw = '0;

    logic                              result_valid;
    logic                              result_stall = 1'b0;
    logic signed [ptc_pkg::OUT_W-1:0]  pressure_out;
    logic signed [ptc_pkg::OUT_W-1:0]  temp_out;

    ptc_tb_pkg::compensation_checker comp_check = new();

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_off_cycles = 0;
    int quiet_cycles = 0;
    int settings_used = 0;
    logic [ptc_pkg::COEF_W-1:0] cur_tref = '0;

    pressure_temp_compensation_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .pressure_raw (pressure_raw),
        .temp_raw     (temp_raw),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pressure_out (pressure_out),
        .temp_out     (temp_out)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Record sample beats and check result beats at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                comp_check.note_sample(pressure_raw, temp_raw);
            if (result_valid && !result_stall)
                comp_check.check_result(pressure_out, temp_out);
        end
    end

    // Abort when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_len;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_len = hold_off_cycles;
                hold_off_cycles = 0;
                repeat (hold_len)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    task automatic set_idling(idling_t mode);
        case (mode)
            IDLE_NONE:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                sender_idle_pct = 87;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 87;
            end
            default:
            begin
                sender_idle_pct = 24;
                receiver_stall_pct = 24;
            end
        endcase
    endtask

    // APB write with setup and access phases; the register takes it at the access edge
    task automatic apb_write(logic [2:0] idx, logic [ptc_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        comp_check.write_register(idx, data);
        // hold the bus idle between transfers
        @(posedge clk);
    endtask

    // Write all calibration words with junk in the unused upper bits
    task automatic load_calibration(logic [ptc_pkg::COEF_W-1:0] c1,
                                    logic [ptc_pkg::COEF_W-1:0] c2,
                                    logic [ptc_pkg::COEF_W-1:0] c3,
                                    logic [ptc_pkg::COEF_W-1:0] c4,
                                    logic [ptc_pkg::COEF_W-1:0] c5,
                                    logic [ptc_pkg::COEF_W-1:0] c6,
                                    logic model);
        apb_write(ptc_pkg::REG_SENS,     {16'($urandom), c1});
        apb_write(ptc_pkg::REG_OFFSET,   {16'($urandom), c2});
        apb_write(ptc_pkg::REG_TCS,      {16'($urandom), c3});
        apb_write(ptc_pkg::REG_TCO,      {16'($urandom), c4});
        apb_write(ptc_pkg::REG_TREF,     {16'($urandom), c5});
        apb_write(ptc_pkg::REG_TEMPSENS, {16'($urandom), c6});
        apb_write(ptc_pkg::REG_MODEL,    {31'($urandom), model});
        apb_write(UNMAPPED_IDX, $urandom);
        cur_tref = c5;
        settings_used++;
    endtask

    // Offer one sample beat and hold it until taken
    task automatic send_sample(logic [ptc_pkg::RAW_W-1:0] d1,
                               logic [ptc_pkg::RAW_W-1:0] d2);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        pressure_raw <= d1;
        temp_raw     <= d2;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait for every expected reading, then for the pipeline to empty
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (comp_check.pending_count() != 0)
            @(posedge clk);
        repeat (ptc_pkg::NUM_STAGES)
            @(posedge clk);
    endtask

    function automatic logic [ptc_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ptc_pkg::COEF_W'($urandom);
        endcase
    endfunction

    // Random raw sample; half the temperatures land near the reference
    task automatic send_random_sample();
        logic [ptc_pkg::RAW_W-1:0] d1;
        logic [ptc_pkg::RAW_W-1:0] d2;
        int                        near;
        case ($urandom_range(0, 15))
            0:       d1 = '0;
            1:       d1 = RAW_MAX;
            default: d1 = ptc_pkg::RAW_W'($urandom);
        endcase
        if ($urandom_range(0, 1) == 0)
        begin
            d2 = ptc_pkg::RAW_W'($urandom);
        end
        else
        begin
            near = int'(cur_tref) * 256 + int'($urandom_range(0, 4194304)) - 2097152;
            if (near < 0)
                near = 0;
            if (near > int'(RAW_MAX))
                near = int'(RAW_MAX);
            d2 = ptc_pkg::RAW_W'(near);
        end
        send_sample(d1, d2);
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: all words zero, 30BA rules
        set_idling(IDLE_NONE);
        settings_used = 1;
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MAX, '0);
        drain_results();

        // Typical 30BA words: extremes, reference point, cold and very cold edges
        load_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646,
                         16'd26146, 1'b0);
        send_sample(24'd4958179, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd4958179, 24'd6821376);
        send_sample('0, 24'd6821055);
        send_sample(24'd4958179, 24'd5666363);
        send_sample(24'd4958179, 24'd5666362);
        drain_results();

        // Same words with 02BA rules: warm and just-below-threshold
        load_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646,
                         16'd26146, 1'b1);
        send_sample(24'd4958179, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd4958179, 24'd6821376);
        send_sample(24'd4958179, 24'd6821055);
        drain_results();

        // Every calibration word at full scale, both models
        for (int m = 1; m >= 0; m--)
        begin
            load_calibration('1, '1, '1, '1, '1, '1, m[0]);
            send_sample('0, '0);
            send_sample(RAW_MAX, RAW_MAX);
            send_sample(RAW_MAX, '0);
            send_sample('0, RAW_MAX);
            drain_results();
        end

        // Long result hold-off while samples keep coming, so the input backs up
        load_calibration(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                         pick_coef(), pick_coef(), 1'($urandom));
        set_idling(IDLE_NONE);
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (60)
            send_random_sample();
        drain_results();

        // Random calibration per phase, cycling through the idling patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_calibration(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                             pick_coef(), pick_coef(), 1'($urandom));
            set_idling(idling_t'(ph % 4));
            repeat (ITEMS_PER_PHASE)
                send_random_sample();
            drain_results();
        end

        $display("Run covered %0d sample beats and %0d checked readings over %0d calibration",
                 comp_check.samples_seen, comp_check.readings_checked, settings_used);
        $display("settings, both models, sender gaps, result stalls and a long result hold-off.");
        if (comp_check.failures == 0 && comp_check.pending_count() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
